/* hw/rtl/cdds_pkg.sv */
// ----------------------------------------------------------------------------
// cdds_pkg - civil date day shift package
// constants, reciprocal factors and small tables shared by the date pipeline
// ----------------------------------------------------------------------------
package cdds_pkg;

    localparam int unsigned STAGES        = 14;

    localparam int unsigned YEAR_W        = 14;
    localparam int unsigned MONTH_W       = 4;
    localparam int unsigned DAY_W         = 5;
    localparam int unsigned DELTA_W       = 23;
    localparam int unsigned OUT_YEAR_W    = 16;

    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned YEARS_PER_ERA = 400;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned DAYS_PER_4Y   = 1460;
    localparam int unsigned DAYS_PER_100Y = 36524;
    localparam int unsigned LAST_DOE      = 146096;

    // eras added so that every day count stays positive
    localparam int unsigned ERA_BIAS      = 32;

    // truncated reciprocals: q = (n * RECIP) >> SHIFT is exact or one low
    localparam int unsigned ERA_Y_SHIFT   = 15;
    localparam int unsigned ERA_Y_RECIP   = (1 << ERA_Y_SHIFT) / YEARS_PER_ERA;
    localparam int unsigned ERA_D_SHIFT   = 24;
    localparam int unsigned ERA_D_RECIP   = (1 << ERA_D_SHIFT) / DAYS_PER_ERA;
    localparam int unsigned Q4Y_SHIFT     = 18;
    localparam int unsigned Q4Y_RECIP     = (1 << Q4Y_SHIFT) / DAYS_PER_4Y;
    localparam int unsigned YEAR_SHIFT    = 18;
    localparam int unsigned YEAR_RECIP    = (1 << YEAR_SHIFT) / DAYS_PER_YEAR;

    // first day of each month in a march-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // n / 100 for n below 400
    function automatic logic [2:0] div100(input logic [8:0] n);
        logic [14:0] p;
        p = 15'(n) * 15'(41);
        return p[14:12];
    endfunction

    // day of era from year of era and day of year
    function automatic logic [17:0] era_day(input logic [8:0] yoe, input logic [8:0] doy);
        return 18'(yoe) * 18'(DAYS_PER_YEAR) + 18'(yoe >> 2) - 18'(div100(yoe)) + 18'(doy);
    endfunction

endpackage

/* hw/rtl/civil_date_day_shift.sv */
// ----------------------------------------------------------------------------
// civil_date_day_shift - shift a gregorian date by a signed number of days
// converts the date to a day count, adds the offset and converts back
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one item of i_year, i_month, i_day
// and i_day_delta; an item is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carry the shifted year,
// month and day with o_status; a result is taken when o_valid is high and
// i_stall low.
// Each item gives exactly one result, in order. A month outside 1..12 or a
// day of zero gives o_status high with the date fields at zero.
// o_valid rises when an accepted item reaches the last stage register, so
// the result can then be taken. One item is accepted every cycle while
// o_stall is low; the rate is set by the 14-stage pipeline of constant
// reciprocal divisions (by 400, 146097, 1460 and 365), one per stage pair.
// When i_stall is high the pipeline closes up its empty stages and keeps
// taking items until every stage holds one; only then does o_stall rise.
// The held result stays unchanged while stalled.
// Synchronous active-low reset empties the pipeline; no result is pending
// after it, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module civil_date_day_shift (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic signed [22:0] i_day_delta,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_shifted_year,
    output logic [3:0]  o_shifted_month,
    output logic [4:0]  o_shifted_day,
    output logic        o_status
);

    localparam int unsigned LAST = cdds_pkg::STAGES - 1;

    logic [LAST:0] r_valid;
    logic [LAST:0] r_err;
    logic [LAST:0] en;

    // stage registers
    logic [14:0] r_s0_yp;
    logic [8:0]  r_s0_doy;
    logic [22:0] r_s0_delta;
    logic [14:0] r_s1_yp;
    logic [5:0]  r_s1_q;
    logic [8:0]  r_s1_doy;
    logic [22:0] r_s1_delta;
    logic [5:0]  r_s2_era;
    logic [8:0]  r_s2_yoe;
    logic [8:0]  r_s2_doy;
    logic [22:0] r_s2_delta;
    logic [17:0] r_s3_doe;
    logic [23:0] r_s3_era_days;
    logic [22:0] r_s3_delta;
    logic [23:0] r_s4_z;
    logic [23:0] r_s5_z;
    logic [6:0]  r_s5_q;
    logic [6:0]  r_s6_era;
    logic [17:0] r_s6_doe;
    logic [6:0]  r_s7_era;
    logic [17:0] r_s7_doe;
    logic [6:0]  r_s7_q;
    logic [2:0]  r_s7_c100;
    logic        r_s7_c400;
    logic [6:0]  r_s8_era;
    logic [17:0] r_s8_doe;
    logic [17:0] r_s8_t;
    logic [6:0]  r_s9_era;
    logic [17:0] r_s9_doe;
    logic [17:0] r_s9_t;
    logic [8:0]  r_s9_q;
    logic [6:0]  r_s10_era;
    logic [17:0] r_s10_doe;
    logic [8:0]  r_s10_yoe;
    logic [8:0]  r_s11_doy;
    logic [15:0] r_s11_year;
    logic [8:0]  r_s12_doy;
    logic [15:0] r_s12_year;
    logic [3:0]  r_s12_mp;
    logic [15:0] r_s13_year;
    logic [3:0]  r_s13_month;
    logic [4:0]  r_s13_day;

    // next values
    logic        n_s0_err;
    logic        n_s0_early;
    logic [3:0]  n_s0_idx;
    logic [14:0] n_s0_yp;
    logic [8:0]  n_s0_doy;
    logic [5:0]  n_s1_q;
    logic [14:0] n_s2_rem;
    logic        n_s2_fix;
    logic [5:0]  n_s2_era;
    logic [8:0]  n_s2_yoe;
    logic [17:0] n_s3_doe;
    logic [23:0] n_s3_era_days;
    logic [24:0] n_s4_sum;
    logic [6:0]  n_s5_q;
    logic [23:0] n_s6_rem;
    logic        n_s6_fix;
    logic [6:0]  n_s6_era;
    logic [17:0] n_s6_doe;
    logic [6:0]  n_s7_q;
    logic [2:0]  n_s7_c100;
    logic        n_s7_c400;
    logic [17:0] n_s8_rem;
    logic [6:0]  n_s8_q;
    logic [17:0] n_s8_t;
    logic [8:0]  n_s9_q;
    logic [17:0] n_s10_rem;
    logic [8:0]  n_s10_yoe;
    logic [8:0]  n_s11_doy;
    logic [16:0] n_s11_year;
    logic [3:0]  n_s12_mp;
    logic [15:0] n_s13_year;
    logic [3:0]  n_s13_month;
    logic [4:0]  n_s13_day;
    logic [8:0]  n_s13_doff;

    // stage enables, a stage loads when empty or when its successor loads
    always_comb begin
        en[LAST] = !r_valid[LAST] || !i_stall;
        for (int k = int'(LAST) - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k + 1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k <= int'(LAST); k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_err[0] <= n_s0_err;
        end
        for (int k = 1; k <= int'(LAST); k++) begin
            if (en[k]) begin
                r_err[k] <= r_err[k - 1];
            end
        end
    end

    // stage 0: range check, march-based year and day of year
    always_comb begin
        n_s0_err   = (i_month == 4'd0) || (i_month > 4'd12) || (i_day == 5'd0);
        n_s0_early = (i_month <= 4'd2);
        n_s0_idx   = n_s0_early ? (i_month + 4'd9) : (i_month - 4'd3);
        n_s0_yp    = 15'(i_year) + 15'(cdds_pkg::YEARS_PER_ERA) - 15'(n_s0_early);
        n_s0_doy   = cdds_pkg::month_start(n_s0_idx) + 9'(i_day) - 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_yp    <= n_s0_yp;
            r_s0_doy   <= n_s0_doy;
            r_s0_delta <= i_day_delta;
        end
    end

    // stage 1: era estimate
    assign n_s1_q = 6'((32'(r_s0_yp) * 32'(cdds_pkg::ERA_Y_RECIP)) >> cdds_pkg::ERA_Y_SHIFT);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_yp    <= r_s0_yp;
            r_s1_q     <= n_s1_q;
            r_s1_doy   <= r_s0_doy;
            r_s1_delta <= r_s0_delta;
        end
    end

    // stage 2: era correction and year of era
    always_comb begin
        n_s2_rem = r_s1_yp - 15'(r_s1_q) * 15'(cdds_pkg::YEARS_PER_ERA);
        n_s2_fix = (n_s2_rem >= 15'(cdds_pkg::YEARS_PER_ERA));
        n_s2_era = r_s1_q + 6'(n_s2_fix);
        n_s2_yoe = n_s2_fix ? 9'(n_s2_rem - 15'(cdds_pkg::YEARS_PER_ERA)) : 9'(n_s2_rem);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_era   <= n_s2_era;
            r_s2_yoe   <= n_s2_yoe;
            r_s2_doy   <= r_s1_doy;
            r_s2_delta <= r_s1_delta;
        end
    end

    // stage 3: day of era and biased era start
    always_comb begin
        n_s3_doe      = cdds_pkg::era_day(r_s2_yoe, r_s2_doy);
        n_s3_era_days = 24'(7'(r_s2_era) + 7'(cdds_pkg::ERA_BIAS - 1))
                        * 24'(cdds_pkg::DAYS_PER_ERA);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_doe      <= n_s3_doe;
            r_s3_era_days <= n_s3_era_days;
            r_s3_delta    <= r_s2_delta;
        end
    end

    // stage 4: add the offset, the biased count stays positive
    assign n_s4_sum = {1'b0, r_s3_era_days} + {7'b0, r_s3_doe}
                    + {{2{r_s3_delta[22]}}, r_s3_delta};

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_z <= n_s4_sum[23:0];
        end
    end

    // stage 5: era estimate of the shifted count
    assign n_s5_q = 7'((32'(r_s4_z) * 32'(cdds_pkg::ERA_D_RECIP)) >> cdds_pkg::ERA_D_SHIFT);

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_z <= r_s4_z;
            r_s5_q <= n_s5_q;
        end
    end

    // stage 6: era correction and day of era
    always_comb begin
        n_s6_rem = r_s5_z - 24'(r_s5_q) * 24'(cdds_pkg::DAYS_PER_ERA);
        n_s6_fix = (n_s6_rem >= 24'(cdds_pkg::DAYS_PER_ERA));
        n_s6_era = r_s5_q + 7'(n_s6_fix);
        n_s6_doe = n_s6_fix ? 18'(n_s6_rem - 24'(cdds_pkg::DAYS_PER_ERA)) : 18'(n_s6_rem);
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_era <= n_s6_era;
            r_s6_doe <= n_s6_doe;
        end
    end

    // stage 7: four-year estimate, century and era-end counts
    always_comb begin
        n_s7_q    = 7'((32'(r_s6_doe) * 32'(cdds_pkg::Q4Y_RECIP)) >> cdds_pkg::Q4Y_SHIFT);
        n_s7_c100 = 3'(r_s6_doe >= 18'(cdds_pkg::DAYS_PER_100Y))
                  + 3'(r_s6_doe >= 18'(2 * cdds_pkg::DAYS_PER_100Y))
                  + 3'(r_s6_doe >= 18'(3 * cdds_pkg::DAYS_PER_100Y))
                  + 3'(r_s6_doe >= 18'(4 * cdds_pkg::DAYS_PER_100Y));
        n_s7_c400 = (r_s6_doe == 18'(cdds_pkg::LAST_DOE));
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_era  <= r_s6_era;
            r_s7_doe  <= r_s6_doe;
            r_s7_q    <= n_s7_q;
            r_s7_c100 <= n_s7_c100;
            r_s7_c400 <= n_s7_c400;
        end
    end

    // stage 8: correct the four-year count, leap-free day count
    always_comb begin
        n_s8_rem = r_s7_doe - 18'(r_s7_q) * 18'(cdds_pkg::DAYS_PER_4Y);
        n_s8_q   = r_s7_q + 7'(n_s8_rem >= 18'(cdds_pkg::DAYS_PER_4Y));
        n_s8_t   = r_s7_doe - 18'(n_s8_q) + 18'(r_s7_c100) - 18'(r_s7_c400);
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_era <= r_s7_era;
            r_s8_doe <= r_s7_doe;
            r_s8_t   <= n_s8_t;
        end
    end

    // stage 9: year of era estimate
    assign n_s9_q = 9'((32'(r_s8_t) * 32'(cdds_pkg::YEAR_RECIP)) >> cdds_pkg::YEAR_SHIFT);

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_era <= r_s8_era;
            r_s9_doe <= r_s8_doe;
            r_s9_t   <= r_s8_t;
            r_s9_q   <= n_s9_q;
        end
    end

    // stage 10: year of era correction
    always_comb begin
        n_s10_rem = r_s9_t - 18'(r_s9_q) * 18'(cdds_pkg::DAYS_PER_YEAR);
        n_s10_yoe = r_s9_q + 9'(n_s10_rem >= 18'(cdds_pkg::DAYS_PER_YEAR));
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_s10_era <= r_s9_era;
            r_s10_doe <= r_s9_doe;
            r_s10_yoe <= n_s10_yoe;
        end
    end

    // stage 11: day of year and unbiased march-based year
    always_comb begin
        n_s11_doy  = 9'(r_s10_doe - cdds_pkg::era_day(r_s10_yoe, 9'd0));
        n_s11_year = 17'(r_s10_yoe) + 17'(r_s10_era) * 17'(cdds_pkg::YEARS_PER_ERA)
                   - 17'(cdds_pkg::ERA_BIAS * cdds_pkg::YEARS_PER_ERA);
    end

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r_s11_doy  <= n_s11_doy;
            r_s11_year <= n_s11_year[15:0];
        end
    end

    // stage 12: march-based month by comparing against month starts
    always_comb begin
        n_s12_mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            n_s12_mp = n_s12_mp + 4'(r_s11_doy >= cdds_pkg::month_start(4'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            r_s12_doy  <= r_s11_doy;
            r_s12_year <= r_s11_year;
            r_s12_mp   <= n_s12_mp;
        end
    end

    // stage 13: calendar month, day and year, error items give zeros
    always_comb begin
        n_s13_doff = r_s12_doy - cdds_pkg::month_start(r_s12_mp) + 9'd1;
        if (r_err[12]) begin
            n_s13_year  = '0;
            n_s13_month = '0;
            n_s13_day   = '0;
        end else begin
            n_s13_year  = r_s12_year + 16'(r_s12_mp >= 4'd10);
            n_s13_month = (r_s12_mp < 4'd10) ? (r_s12_mp + 4'd3) : (r_s12_mp - 4'd9);
            n_s13_day   = n_s13_doff[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[13]) begin
            r_s13_year  <= n_s13_year;
            r_s13_month <= n_s13_month;
            r_s13_day   <= n_s13_day;
        end
    end

    assign o_valid         = r_valid[LAST];
    assign o_shifted_year  = $signed(r_s13_year);
    assign o_shifted_month = r_s13_month;
    assign o_shifted_day   = r_s13_day;
    assign o_status        = r_err[LAST];

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |->
            o_shifted_year == 16'sd0 && o_shifted_month == 4'd0 && o_shifted_day == 5'd0)
        else $error("error item with non-zero date");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |->
            o_shifted_month >= 4'd1 && o_shifted_month <= 4'd12 && o_shifted_day != 5'd0)
        else $error("shifted month or day out of range");

    a_yoe_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[3] && $past(en[2]) |-> $past(n_s2_yoe) < 9'd400)
        else $error("input year of era not corrected");

    a_doe_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[6] |-> r_s6_doe <= 18'(cdds_pkg::LAST_DOE))
        else $error("day of era not corrected");

    a_yoe_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[10] |-> r_s10_yoe < 9'd400)
        else $error("output year of era not corrected");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid) && i_stall)
        else $error("input stalled with an empty stage");
`endif

endmodule
